// ===== rtl/core/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared types and constants for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  localparam work_t InitValue = '{
    a: 32'h6745_2301,
    b: 32'hEFCD_AB89,
    c: 32'h98BA_DCFE,
    d: 32'h1032_5476,
    e: 32'hC3D2_E1F0
  };

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [2:0] LastWord  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Byte-serial SHA-1 with one shared round unit and a 16-word schedule window.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       request    in_valid_i/in_stall_o  data_byte, byte_valid, end_of_message
//  out      result     out_valid_o/out_stall_i digest_word, word_index, last_word
//
// Bytes are taken while idle; the 64th byte of a block starts the rounds of the
// single round unit, then the fold. End of message inserts padding one byte per
// cycle (up to 72) through the same byte path, with one or two compressions,
// then five digest words. in_stall_o is high except when idle.
// Reset loads the initial chaining value and clears the byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  state_e      state_q, state_d;
  work_t       cv_q, cv_d;
  work_t       wv_q, wv_d;
  work_t       rnd_out;
  logic [60:0] count_q, count_d;
  logic [60:0] count_next;
  logic [63:0] len_q, len_d;
  logic [6:0]  rnd_q, rnd_d;
  logic        first_q, first_d;
  logic        lenph_q, lenph_d;
  logic        pad_q, pad_d;
  logic [2:0]  idx_q, idx_d;
  logic [23:0] word_q, word_d;
  logic [31:0] win_q [16];
  logic [31:0] sched;
  logic [31:0] win_in;
  logic        win_shift;
  logic        ins_en;
  logic [7:0]  ins_byte;
  logic [5:0]  pos;

  assign pos        = count_q[5:0];
  assign count_next = count_q + 61'(byte_valid_i);
  assign sched      = {win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
                       win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};

  sha1_round u_round (
    .work_i (wv_q),
    .w_i    (win_q[0]),
    .rnd_i  (rnd_q),
    .work_o (rnd_out)
  );

  always_comb begin
    state_d  = state_q;
    cv_d     = cv_q;
    wv_d     = wv_q;
    count_d  = count_q;
    len_d    = len_q;
    rnd_d    = rnd_q;
    first_d  = first_q;
    lenph_d  = lenph_q;
    pad_d    = pad_q;
    idx_d    = idx_q;
    ins_en   = 1'b0;
    ins_byte = data_byte_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ins_en = byte_valid_i;
          pad_d  = end_of_message_i;
          if (end_of_message_i) begin
            len_d   = {count_next, 3'b000};
            first_d = 1'b1;
            lenph_d = 1'b0;
          end
          if (byte_valid_i && pos == 6'd63) begin
            state_d = ST_ROUND;
            wv_d    = cv_q;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        wv_d  = rnd_out;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == LastRound) begin
          rnd_d   = '0;
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cv_d.a = cv_q.a + wv_q.a;
        cv_d.b = cv_q.b + wv_q.b;
        cv_d.c = cv_q.c + wv_q.c;
        cv_d.d = cv_q.d + wv_q.d;
        cv_d.e = cv_q.e + wv_q.e;
        if (lenph_q) begin
          state_d = ST_OUT;
          idx_d   = '0;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        ins_en  = 1'b1;
        first_d = 1'b0;
        if (first_q) begin
          ins_byte = PadByte;
        end else if (lenph_q) begin
          ins_byte = len_q[63:56];
          len_d    = {len_q[55:0], 8'h00};
        end else begin
          ins_byte = 8'h00;
        end
        if (pos == 6'd55) begin
          lenph_d = 1'b1;
        end
        if (pos == 6'd63) begin
          state_d = ST_ROUND;
          wv_d    = cv_q;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (idx_q == LastWord) begin
            state_d = ST_IDLE;
            cv_d    = InitValue;
            wv_d    = '0;
            pad_d   = 1'b0;
            lenph_d = 1'b0;
            count_d = '0;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (ins_en) begin
      count_d = count_q + 61'd1;
    end
    word_d    = ins_en ? {word_q[15:0], ins_byte} : word_q;
    win_shift = (ins_en && pos[1:0] == 2'b11) || state_q == ST_ROUND;
    win_in    = (state_q == ST_ROUND) ? sched : {word_q, ins_byte};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cv_q    <= InitValue;
      wv_q    <= '0;
      count_q <= '0;
      rnd_q   <= '0;
      first_q <= 1'b0;
      lenph_q <= 1'b0;
      pad_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cv_q    <= cv_d;
      wv_q    <= wv_d;
      count_q <= count_d;
      rnd_q   <= rnd_d;
      first_q <= first_d;
      lenph_q <= lenph_d;
      pad_q   <= pad_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    word_q <= word_d;
    if (win_shift) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= win_in;
    end
  end

  always_comb begin
    case (idx_q)
      3'd0:    digest_word_o = cv_q.a;
      3'd1:    digest_word_o = cv_q.b;
      3'd2:    digest_word_o = cv_q.c;
      3'd3:    digest_word_o = cv_q.d;
      3'd4:    digest_word_o = cv_q.e;
      default: digest_word_o = '0;
    endcase
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = state_q == ST_OUT;
  assign word_index_o = idx_q;
  assign last_word_o  = idx_q == LastWord;

endmodule

`default_nettype wire

// ===== rtl/core/sha1_round.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: round function, constant select and rotate/add.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_round
  import sha1_pkg::*;
(
  input  work_t       work_i,
  input  logic [31:0] w_i,
  input  logic [6:0]  rnd_i,
  output work_t       work_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    if (rnd_i < 7'd20) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = K0;
    end else if (rnd_i < 7'd40) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K1;
    end else if (rnd_i < 7'd60) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K3;
    end
    t = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + w_i;
    work_o = '{
      a: t,
      b: work_i.a,
      c: {work_i.b[1:0], work_i.b[31:2]},
      d: work_i.c,
      e: work_i.d
    };
  end

endmodule

`default_nettype wire
